// ===== rtl/sslb_pkg.sv =====
package sslb_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int CNT_W         = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [2:0] OP_START       = 3'd0;
    localparam logic [2:0] OP_STOP        = 3'd1;
    localparam logic [2:0] OP_HOME_DONE   = 3'd2;
    localparam logic [2:0] OP_MEAS_DONE   = 3'd3;
    localparam logic [2:0] OP_MOTION_DONE = 3'd4;

    localparam logic [3:0] KIND_MEASURE = 4'd0;
    localparam logic [3:0] KIND_REL_X   = 4'd1;
    localparam logic [3:0] KIND_REL_Y   = 4'd2;
    localparam logic [3:0] KIND_ABS_X   = 4'd3;
    localparam logic [3:0] KIND_ABS_Y   = 4'd4;
    localparam logic [3:0] KIND_ESTOP   = 4'd5;
    localparam logic [3:0] KIND_HEADER  = 4'd6;
    localparam logic [3:0] KIND_PIXEL   = 4'd7;
    localparam logic [3:0] KIND_DONE    = 4'd8;

    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_STEP_X   = 3'd2;
    localparam logic [2:0] CFG_STEP_Y   = 3'd3;
    localparam logic [2:0] CFG_OFFSET_X = 3'd4;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [2:0] CFG_FAST     = 3'd6;
    localparam logic [2:0] CFG_SLOW     = 3'd7;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] amount;
        logic [16:0] clk;
    } t_cmd;

    // one accepted word's worth of output, plus the pixel it stores
    typedef struct packed {
        logic [1:0]       pre_n;
        t_cmd [1:0]       cmd;
        logic             hdr;
        logic [11:0]      line_offset;
        logic [11:0]      line_number;
        logic [CNT_W-1:0] pix_n;
        logic [CNT_W-1:0] pix_start;
        logic             done;
        logic             wr_en;
        logic [CNT_W-1:0] wr_addr;
        logic [31:0]      wr_dist;
        logic [15:0]      wr_amp;
    } t_job;

    function automatic t_cmd make_cmd(logic [3:0] k, logic [15:0] a, logic [16:0] c);
        t_cmd r;
        r.kind   = k;
        r.amount = a;
        r.clk    = c;
        return r;
    endfunction

endpackage

// ===== rtl/sslb_front.sv =====
module sslb_front #(
    parameter int LINE_BUFFER_DEPTH = sslb_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_operation,
    input  logic [31:0]       i_distance,
    input  logic [15:0]       i_amplitude,
    input  logic              i_measure_ok,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [16:0]       i_cfg_data,
    output logic              o_push,
    output sslb_pkg::t_job    o_job,
    input  logic              i_full
);

    localparam int CW = sslb_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(LINE_BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_M1 = CW'(LINE_BUFFER_DEPTH - 1);

    typedef enum logic [5:0] {
        MODE_STOPPED  = 6'b000001,
        MODE_FORWARD  = 6'b000010,
        MODE_BACKWARD = 6'b000100,
        MODE_BUSY     = 6'b001000,
        MODE_PENDING  = 6'b010000,
        MODE_PAUSED   = 6'b100000
    } t_mode;

    logic [11:0] r_width, r_height;
    logic [9:0]  r_step_x, r_step_y;
    logic [15:0] r_off_x, r_off_y;
    logic [16:0] r_fast, r_slow;

    t_mode          r_mode, n_mode;
    logic           r_saved, n_saved;
    logic           r_pause, n_pause;
    logic [12:0]    r_col, n_col;
    logic [12:0]    r_row, n_row;
    logic [CW-1:0]  r_bcount, n_bcount;

    logic           accept, fwd, run, endp, last_row;
    logic [CW-1:0]  cc, idx, cnt;
    logic [12:0]    col_s, row_s, off_s;
    sslb_pkg::t_job job;

    assign o_in_stall  = i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_full;
    assign o_push      = accept && (job.pre_n != 2'd0);
    assign o_job       = job;

    assign fwd      = (r_mode == MODE_FORWARD);
    assign run      = (r_mode == MODE_FORWARD) || (r_mode == MODE_BACKWARD);
    assign cc       = (r_bcount >= DEPTH_C) ? DEPTH_M1 : r_bcount;
    assign idx      = fwd ? cc : DEPTH_M1 - cc;
    assign cnt      = cc + CW'(1);
    assign col_s    = fwd ? r_col + 13'd1 : r_col - 13'd1;
    assign endp     = (col_s == 13'd0) || (col_s == {1'b0, r_width});
    assign row_s    = r_row + 13'd1;
    assign last_row = (row_s == {1'b0, r_height});
    assign off_s    = col_s - 13'(cnt);

    always_comb begin
        n_mode   = r_mode;
        n_saved  = r_saved;
        n_pause  = r_pause;
        n_col    = r_col;
        n_row    = r_row;
        n_bcount = r_bcount;
        job      = '0;
        unique case (i_operation)
            sslb_pkg::OP_START: begin
                n_pause = 1'b0;
                if (run) begin
                    n_pause = 1'b1;
                end else if (r_mode == MODE_PAUSED) begin
                    n_mode = r_saved ? MODE_BACKWARD : MODE_FORWARD;
                    job.pre_n  = 2'd1;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_MEASURE, '0, '0);
                end else begin
                    n_mode = MODE_BUSY;
                    job.pre_n  = 2'd2;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_X, r_off_x, r_slow);
                    job.cmd[1] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_Y, r_off_y, r_slow);
                end
            end
            sslb_pkg::OP_STOP: begin
                if (run) begin
                    n_mode = MODE_PENDING;
                end else if (r_mode == MODE_PAUSED) begin
                    n_mode = MODE_STOPPED;
                    job.pre_n  = 2'd2;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_X, r_off_x, r_fast);
                    job.cmd[1] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_Y, r_off_y, r_fast);
                end else if (r_mode == MODE_BUSY) begin
                    n_mode = MODE_STOPPED;
                    job.pre_n  = 2'd1;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_ESTOP, '0, '0);
                end
            end
            sslb_pkg::OP_HOME_DONE: begin
                if (r_mode == MODE_BUSY) begin
                    n_bcount = '0;
                    n_col    = '0;
                    n_row    = '0;
                    n_mode   = MODE_FORWARD;
                    job.pre_n  = 2'd1;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_MEASURE, '0, '0);
                end
            end
            sslb_pkg::OP_MOTION_DONE: begin
                if (run && r_pause) begin
                    n_saved = (r_mode == MODE_BACKWARD);
                    n_mode  = MODE_PAUSED;
                end else if (run || r_mode == MODE_PENDING) begin
                    job.pre_n  = 2'd1;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_MEASURE, '0, '0);
                end
            end
            sslb_pkg::OP_MEAS_DONE: begin
                if (r_mode == MODE_PENDING) begin
                    n_mode = MODE_STOPPED;
                    job.pre_n  = 2'd2;
                    job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_X, r_off_x, r_slow);
                    job.cmd[1] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_Y, r_off_y, r_slow);
                end else if (run) begin
                    n_col    = col_s;
                    n_bcount = cnt;
                    job.pre_n = 2'd1;
                    if (endp) begin
                        n_row = row_s;
                        if (last_row) begin
                            n_mode     = MODE_STOPPED;
                            job.pre_n  = 2'd2;
                            job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_X, r_off_x,
                                                            r_slow);
                            job.cmd[1] = sslb_pkg::make_cmd(sslb_pkg::KIND_ABS_Y, r_off_y,
                                                            r_slow);
                            job.done   = i_measure_ok;
                        end else begin
                            n_mode     = fwd ? MODE_BACKWARD : MODE_FORWARD;
                            job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_REL_Y,
                                                            {6'd0, r_step_y}, r_slow);
                        end
                    end else begin
                        job.cmd[0] = sslb_pkg::make_cmd(sslb_pkg::KIND_REL_X,
                            fwd ? {6'd0, r_step_x} : 16'd0 - {6'd0, r_step_x}, r_fast);
                    end
                    if (i_measure_ok) begin
                        job.wr_en   = 1'b1;
                        job.wr_addr = idx;
                        job.wr_dist = i_distance;
                        job.wr_amp  = i_amplitude;
                        if (endp || cnt == DEPTH_C) begin
                            job.hdr         = 1'b1;
                            job.line_offset = fwd ? off_s[11:0] : col_s[11:0];
                            job.line_number = r_row[11:0];
                            job.pix_n       = cnt;
                            job.pix_start   = fwd ? '0 : idx;
                            n_bcount        = '0;
                        end
                    end else begin
                        n_mode = MODE_STOPPED;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_STOPPED;
            r_saved  <= 1'b0;
            r_pause  <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_bcount <= '0;
            r_width  <= 12'd5;
            r_height <= 12'd5;
            r_step_x <= 10'd1;
            r_step_y <= 10'd1;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_fast   <= 17'd3000;
            r_slow   <= 17'd1000;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_saved  <= n_saved;
                r_pause  <= n_pause;
                r_col    <= n_col;
                r_row    <= n_row;
                r_bcount <= n_bcount;
            end
            // drop writes unless the scan is stopped
            if (i_cfg_valid && r_mode == MODE_STOPPED) begin
                case (i_cfg_index)
                    sslb_pkg::CFG_WIDTH:    r_width  <= i_cfg_data[11:0];
                    sslb_pkg::CFG_HEIGHT:   r_height <= i_cfg_data[11:0];
                    sslb_pkg::CFG_STEP_X:   r_step_x <= i_cfg_data[9:0];
                    sslb_pkg::CFG_STEP_Y:   r_step_y <= i_cfg_data[9:0];
                    sslb_pkg::CFG_OFFSET_X: r_off_x  <= i_cfg_data[15:0];
                    sslb_pkg::CFG_OFFSET_Y: r_off_y  <= i_cfg_data[15:0];
                    sslb_pkg::CFG_FAST:     r_fast   <= i_cfg_data;
                    default:                r_slow   <= i_cfg_data;
                endcase
            end
        end
    end

endmodule

// ===== rtl/sslb_queue.sv =====
module sslb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sslb_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output sslb_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int QD  = sslb_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

    sslb_pkg::t_job r_mem [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QD - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QD - 1)) ? '0 : r_rp + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/sslb_back.sv =====
module sslb_back #(
    parameter int LINE_BUFFER_DEPTH = sslb_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sslb_pkg::t_job     i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_kind,
    output logic signed [15:0] o_amount,
    output logic [16:0]        o_clock_rate,
    output logic [11:0]        o_line_offset,
    output logic [11:0]        o_line_number,
    output logic [5:0]         o_pixel_count,
    output logic [31:0]        o_pixel_distance,
    output logic [15:0]        o_pixel_amplitude,
    output logic               o_last
);

    localparam int CW = sslb_pkg::CNT_W;
    localparam int AW = (LINE_BUFFER_DEPTH > 1) ? $clog2(LINE_BUFFER_DEPTH) : 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PRE0 = 7'b0000010,
        ST_PRE1 = 7'b0000100,
        ST_HDR  = 7'b0001000,
        ST_RD   = 7'b0010000,
        ST_PIX  = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state             r_state;
    sslb_pkg::t_job     r_job;
    logic [CW-1:0]      r_addr, r_left;
    logic [47:0]        r_mem [LINE_BUFFER_DEPTH];
    logic [47:0]        r_rdata;
    logic               free, emit;
    logic [3:0]         n_kind;
    logic signed [15:0] n_amount;
    logic [16:0]        n_clock_rate;
    logic [11:0]        n_line_offset;
    logic [11:0]        n_line_number;
    logic [5:0]         n_pixel_count;
    logic [31:0]        n_pixel_distance;
    logic [15:0]        n_pixel_amplitude;
    logic               n_last;

    assign free  = !o_out_valid || !i_out_stall;
    assign emit  = free && (r_state != ST_IDLE) && (r_state != ST_RD);
    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.wr_en) begin
            r_mem[i_job.wr_addr[AW-1:0]] <= {i_job.wr_dist, i_job.wr_amp};
        end
        if (r_state == ST_RD) begin
            r_rdata <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // hold the word while the receiver stalls
            o_out_valid <= emit || (o_out_valid && i_out_stall);
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= ST_PRE0;
                    end
                end
                ST_PRE0: begin
                    if (free) begin
                        if (r_job.pre_n == 2'd2) begin
                            r_state <= ST_PRE1;
                        end else if (r_job.hdr) begin
                            r_state <= ST_HDR;
                        end else if (r_job.done) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_PRE1: begin
                    if (free) begin
                        if (r_job.hdr) begin
                            r_state <= ST_HDR;
                        end else if (r_job.done) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_HDR: begin
                    if (free) begin
                        r_addr  <= r_job.pix_start;
                        r_left  <= r_job.pix_n;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_PIX;
                end
                ST_PIX: begin
                    if (free) begin
                        r_addr <= r_addr + CW'(1);
                        r_left <= r_left - CW'(1);
                        if (r_left != CW'(1)) begin
                            r_state <= ST_RD;
                        end else if (r_job.done) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_DONE: begin
                    if (free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        n_kind            = '0;
        n_amount          = '0;
        n_clock_rate      = '0;
        n_line_offset     = '0;
        n_line_number     = '0;
        n_pixel_count     = '0;
        n_pixel_distance  = '0;
        n_pixel_amplitude = '0;
        n_last            = 1'b0;
        unique case (r_state)
            ST_PRE0: begin
                n_kind       = r_job.cmd[0].kind;
                n_amount     = $signed(r_job.cmd[0].amount);
                n_clock_rate = r_job.cmd[0].clk;
                n_last       = (r_job.pre_n == 2'd1) && !r_job.hdr && !r_job.done;
            end
            ST_PRE1: begin
                n_kind       = r_job.cmd[1].kind;
                n_amount     = $signed(r_job.cmd[1].amount);
                n_clock_rate = r_job.cmd[1].clk;
                n_last       = !r_job.hdr && !r_job.done;
            end
            ST_HDR: begin
                n_kind        = sslb_pkg::KIND_HEADER;
                n_line_offset = r_job.line_offset;
                n_line_number = r_job.line_number;
                n_pixel_count = r_job.pix_n;
            end
            ST_PIX: begin
                n_kind            = sslb_pkg::KIND_PIXEL;
                n_pixel_distance  = r_rdata[47:16];
                n_pixel_amplitude = r_rdata[15:0];
                n_last            = (r_left == CW'(1)) && !r_job.done;
            end
            ST_DONE: begin
                n_kind = sslb_pkg::KIND_DONE;
                n_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result word, loaded whenever the slot frees up in an emitting state
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_kind            <= n_kind;
            o_amount          <= n_amount;
            o_clock_rate      <= n_clock_rate;
            o_line_offset     <= n_line_offset;
            o_line_number     <= n_line_number;
            o_pixel_count     <= n_pixel_count;
            o_pixel_distance  <= n_pixel_distance;
            o_pixel_amplitude <= n_pixel_amplitude;
            o_last            <= n_last;
        end
    end

endmodule

// ===== rtl/serpentine_scan_line_buffer_core.sv =====
// Serpentine raster scan controller with a line buffer.
// Input channel: one event word per handshake (i_in_valid high, o_in_stall
// low) carrying the operation and, for a measurement, range, amplitude and
// the evaluation flag. The front decodes the event, updates the scan state
// and queues a job; the back turns each job into result words.
// Output channel: result words (o_out_valid, i_out_stall); o_last marks the
// final word caused by an event. Events that cause nothing emit no word.
// Configuration: i_cfg_valid/o_cfg_ready with a register index; writes take
// effect only while the scan is stopped.
// An accepted event is written into the job queue, the back loads it in its
// idle state, and each result word is registered from an emitting state.
// The back takes a new job only once it has finished the last one; move,
// header and done words go out in turn, and each pixel waits on a
// registered line-buffer read. The job queue holds two jobs, so the front
// keeps accepting while the back drains a line, until the queue is full.
// Reset: scan stopped, buffer empty, registers at their defaults.
// A stalled receiver holds the current word; the back waits, the queue fills
// and then o_in_stall rises.
module serpentine_scan_line_buffer_core #(
    parameter int LINE_BUFFER_DEPTH = sslb_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic [31:0]        i_distance,
    input  logic [15:0]        i_amplitude,
    input  logic               i_measure_ok,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_kind,
    output logic signed [15:0] o_amount,
    output logic [16:0]        o_clock_rate,
    output logic [11:0]        o_line_offset,
    output logic [11:0]        o_line_number,
    output logic [5:0]         o_pixel_count,
    output logic [31:0]        o_pixel_distance,
    output logic [15:0]        o_pixel_amplitude,
    output logic               o_last
);

    logic           push, full, pop, empty;
    sslb_pkg::t_job job_in, job_out;

    sslb_front #(.LINE_BUFFER_DEPTH(LINE_BUFFER_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_operation, .i_distance, .i_amplitude, .i_measure_ok,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_push(push), .o_job(job_in), .i_full(full)
    );

    sslb_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_job(job_in), .o_full(full),
        .i_pop(pop), .o_job(job_out), .o_empty(empty)
    );

    sslb_back #(.LINE_BUFFER_DEPTH(LINE_BUFFER_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_job(job_out), .i_empty(empty), .o_pop(pop),
        .o_out_valid, .i_out_stall, .o_kind, .o_amount, .o_clock_rate,
        .o_line_offset, .o_line_number, .o_pixel_count,
        .o_pixel_distance, .o_pixel_amplitude, .o_last
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("job pushed into full queue");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == sslb_pkg::KIND_DONE) |-> o_last)
        else $error("done word not marked last");

    a_header_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == sslb_pkg::KIND_HEADER) |-> (o_pixel_count != '0 && !o_last))
        else $error("line header without pixels");

endmodule
